[hw/rtl/cartesian_to_polar_assert.svh]
// Assertion macros for the cartesian_to_polar block.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef CARTESIAN_TO_POLAR_ASSERT_SVH
`define CARTESIAN_TO_POLAR_ASSERT_SVH
`ifndef SYNTH
`define C2P_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c2p: same-cycle check failed");
`define C2P_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c2p: next-cycle check failed");
`else
`define C2P_ASSERT_IMPL(label, ante, cons)
`define C2P_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/c2p_pkg.sv]
// Shared constants, types and stage-count functions for cartesian_to_polar.
// No dependencies; imported by every module of the block.
package c2p_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int ANGLE_BITS_DEF = 16;

   // The CORDIC datapath is fixed: 64-bit signed x and y with the magnitude
   // scaled to 60 fractional bits, and a 32-bit angle accumulator.
   localparam int CORDIC_ITERS  = 30;
   localparam int CORDIC_W      = 64;
   localparam int CORDIC_FRAC   = 60;
   localparam int ACC_W         = 32;
   localparam int CORDIC_STAGES = CORDIC_ITERS + 1;

   // atan(2^-i) in units of 2^32 per turn, rounded to nearest.
   localparam logic [ACC_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'd667544,   32'd333772,   32'd166886,   32'd83443,    32'd41722,
      32'd20861,    32'd10430,    32'd5215,     32'd2608,     32'd1304,
      32'd652,      32'd326,      32'd163,      32'd81,       32'd41,
      32'd20,       32'd10,       32'd5,        32'd3,        32'd1
   };

   typedef struct packed {
      logic dx_neg;
      logic dy_neg;
      logic is_zero;
   } quad_type;

   // Squares, sum, one stage per root bit, rounding.
   function automatic int isqrt_stages(input int coord_bits);
      return coord_bits + 4;
   endfunction

   // Front stage plus the longer of the two back-end datapaths.
   function automatic int pipe_stages(input int coord_bits);
      int s;
      s = isqrt_stages(coord_bits);
      return 1 + ((s > CORDIC_STAGES) ? s : CORDIC_STAGES);
   endfunction

endpackage

[hw/rtl/c2p_pipe_ctrl.sv]
// Valid bits and per-stage load enables of the cartesian_to_polar pipeline.
// Depends on c2p_pkg.
module c2p_pipe_ctrl import c2p_pkg::*; #(
   parameter int STAGES = pipe_stages(COORD_BITS_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_stall,
   output logic              req_stall,
   output logic [STAGES-1:0] stage_en,
   output logic [STAGES-1:0] stage_valid
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;

   // A stage may load when the output drains or any stage at or after it is
   // empty, so bubbles collapse while the result side is stalled.
   genvar k;
   generate
      for (k = 0; k < STAGES; k++) begin : g_en
         assign stage_en[k] = !rsp_stall || !(&valid_ff[STAGES-1:k]);
      end
   endgenerate

   assign valid_in    = {valid_ff[STAGES-2:0], req_valid};
   assign req_stall   = !stage_en[0];
   assign stage_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (stage_en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

endmodule

[hw/rtl/c2p_cordic.sv]
// Unrolled CORDIC vectoring pipeline with quadrant unfolding and rounding.
// Depends on c2p_pkg; enables come from c2p_pipe_ctrl.
module c2p_cordic import c2p_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
   parameter int BACK_STAGES = pipe_stages(COORD_BITS) - 1
) (
   input  logic                   clock,
   input  logic [BACK_STAGES-1:0] stage_en,
   input  logic [COORD_BITS-1:0]  abs_x,
   input  logic [COORD_BITS-1:0]  abs_y,
   input  quad_type               quad,
   output logic [ANGLE_BITS-1:0]  direction
);

   localparam int PAD       = BACK_STAGES - CORDIC_STAGES;
   localparam int PRE_SHIFT = CORDIC_FRAC - COORD_BITS;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);
   localparam logic [ACC_W-1:0] HALF_TURN  = ACC_W'(1) << (ACC_W - 1);

   logic signed [CORDIC_W-1:0] x_ff    [CORDIC_ITERS];
   logic signed [CORDIC_W-1:0] y_ff    [CORDIC_ITERS];
   logic        [ACC_W-1:0]    z_ff    [CORDIC_ITERS];
   quad_type                   quad_ff [CORDIC_ITERS];

   logic [ACC_W-1:0]      z_last;
   logic [ACC_W-1:0]      angle;
   logic [ACC_W-1:0]      angle_rnd;
   quad_type              quad_last;
   logic [ANGLE_BITS-1:0] dir_in;
   logic [ANGLE_BITS-1:0] dir_ff;

   genvar i;
   generate
      for (i = 0; i < CORDIC_ITERS; i++) begin : g_iter
         logic signed [CORDIC_W-1:0] x_cur;
         logic signed [CORDIC_W-1:0] y_cur;
         logic signed [CORDIC_W-1:0] x_in;
         logic signed [CORDIC_W-1:0] y_in;
         logic        [ACC_W-1:0]    z_cur;
         logic        [ACC_W-1:0]    z_in;
         quad_type                   quad_cur;

         if (i == 0) begin : g_first
            assign x_cur    = CORDIC_W'(abs_x) << PRE_SHIFT;
            assign y_cur    = CORDIC_W'(abs_y) << PRE_SHIFT;
            assign z_cur    = '0;
            assign quad_cur = quad;
         end else begin : g_next
            assign x_cur    = x_ff[i-1];
            assign y_cur    = y_ff[i-1];
            assign z_cur    = z_ff[i-1];
            assign quad_cur = quad_ff[i-1];
         end

         // Rotate toward the x axis; both updates use the old x and y.
         always_comb begin
            if (!y_cur[CORDIC_W-1]) begin
               x_in = x_cur + (y_cur >>> i);
               y_in = y_cur - (x_cur >>> i);
               z_in = z_cur + ATAN_TAB[i];
            end else begin
               x_in = x_cur - (y_cur >>> i);
               y_in = y_cur + (x_cur >>> i);
               z_in = z_cur - ATAN_TAB[i];
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en[i]) begin
               x_ff[i]    <= x_in;
               y_ff[i]    <= y_in;
               z_ff[i]    <= z_in;
               quad_ff[i] <= quad_cur;
            end
         end
      end
   endgenerate

   assign z_last    = z_ff[CORDIC_ITERS-1];
   assign quad_last = quad_ff[CORDIC_ITERS-1];

   // Map the first-quadrant angle back to the quadrant of (dx, dy).
   always_comb begin
      if (quad_last.dx_neg) begin
         angle = quad_last.dy_neg ? (HALF_TURN + z_last) : (HALF_TURN - z_last);
      end else begin
         angle = quad_last.dy_neg ? (ACC_W'(0) - z_last) : z_last;
      end
      angle_rnd = angle + ROUND_HALF;
      dir_in    = quad_last.is_zero ? '0 : angle_rnd[ACC_W-1 -: ANGLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (stage_en[CORDIC_ITERS]) begin
         dir_ff <= dir_in;
      end
   end

   generate
      if (PAD == 0) begin : g_no_pad
         assign direction = dir_ff;
      end else begin : g_pad
         logic [ANGLE_BITS-1:0] pad_ff [PAD];
         genvar p;
         for (p = 0; p < PAD; p++) begin : g_pad_stage
            always_ff @(posedge clock) begin
               if (stage_en[CORDIC_STAGES+p]) begin
                  pad_ff[p] <= (p == 0) ? dir_ff : pad_ff[(p == 0) ? 0 : p-1];
               end
            end
         end
         assign direction = pad_ff[PAD-1];
      end
   endgenerate

endmodule

[hw/rtl/c2p_isqrt.sv]
// Pipelined rounded integer square root of ax^2 + ay^2, one root bit a stage.
// Depends on c2p_pkg; enables come from c2p_pipe_ctrl.
module c2p_isqrt import c2p_pkg::*; #(
   parameter int COORD_BITS  = COORD_BITS_DEF,
   parameter int BACK_STAGES = pipe_stages(COORD_BITS) - 1
) (
   input  logic                   clock,
   input  logic [BACK_STAGES-1:0] stage_en,
   input  logic [COORD_BITS-1:0]  abs_x,
   input  logic [COORD_BITS-1:0]  abs_y,
   output logic [COORD_BITS:0]    distance
);

   localparam int DW    = COORD_BITS + 1;
   localparam int QW    = 2 * COORD_BITS;
   localparam int SW    = QW + 1;
   localparam int TW    = SW + 1;
   localparam int STEP0 = 2;
   localparam int OWN   = isqrt_stages(COORD_BITS);
   localparam int PAD   = BACK_STAGES - OWN;

   logic [QW-1:0] sq_x_in;
   logic [QW-1:0] sq_y_in;
   logic [QW-1:0] sq_x_ff;
   logic [QW-1:0] sq_y_ff;
   logic [SW-1:0] sum_ff;

   logic [SW-1:0] rem_ff  [DW];
   logic [DW-1:0] root_ff [DW];

   logic [DW-1:0] dist_in;
   logic [DW-1:0] dist_ff;

   assign sq_x_in = abs_x * abs_x;
   assign sq_y_in = abs_y * abs_y;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
      end
      if (stage_en[1]) begin
         sum_ff <= SW'(sq_x_ff) + SW'(sq_y_ff);
      end
   end

   // Restoring square root: the remainder holds s - root^2, and setting bit B
   // costs root * 2^(B+1) + 2^(2B).
   genvar j;
   generate
      for (j = 0; j < DW; j++) begin : g_step
         localparam int B = DW - 1 - j;
         logic [SW-1:0] rem_cur;
         logic [SW-1:0] rem_in;
         logic [DW-1:0] root_cur;
         logic [DW-1:0] root_in;
         logic [TW-1:0] trial;

         if (j == 0) begin : g_first
            assign rem_cur  = sum_ff;
            assign root_cur = '0;
         end else begin : g_next
            assign rem_cur  = rem_ff[j-1];
            assign root_cur = root_ff[j-1];
         end

         always_comb begin
            trial = (TW'(root_cur) << (B + 1)) | (TW'(1) << (2 * B));
            if (trial <= TW'(rem_cur)) begin
               rem_in  = rem_cur - SW'(trial);
               root_in = root_cur | (DW'(1) << B);
            end else begin
               rem_in  = rem_cur;
               root_in = root_cur;
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en[STEP0+j]) begin
               rem_ff[j]  <= rem_in;
               root_ff[j] <= root_in;
            end
         end
      end
   endgenerate

   // Round up when s exceeds root * (root + 1), that is remainder > root.
   assign dist_in = (rem_ff[DW-1] > SW'(root_ff[DW-1])) ?
                    (root_ff[DW-1] + DW'(1)) : root_ff[DW-1];

   always_ff @(posedge clock) begin
      if (stage_en[STEP0+DW]) begin
         dist_ff <= dist_in;
      end
   end

   generate
      if (PAD == 0) begin : g_no_pad
         assign distance = dist_ff;
      end else begin : g_pad
         logic [DW-1:0] pad_ff [PAD];
         genvar p;
         for (p = 0; p < PAD; p++) begin : g_pad_stage
            always_ff @(posedge clock) begin
               if (stage_en[OWN+p]) begin
                  pad_ff[p] <= (p == 0) ? dist_ff : pad_ff[(p == 0) ? 0 : p-1];
               end
            end
         end
         assign distance = pad_ff[PAD-1];
      end
   endgenerate

endmodule

[hw/rtl/cartesian_to_polar.sv]
// Top level of cartesian_to_polar: front stage, pipeline control, CORDIC and root.
// Depends on c2p_pkg, c2p_pipe_ctrl, c2p_cordic, c2p_isqrt and the assert header.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+------------------------
//   req     | req_valid, req_stall, req_start_x/y,    | in: one point pair
//           | req_end_x/y                             |
//   rsp     | rsp_valid, rsp_stall, rsp_distance,     | out: distance, angle
//           | rsp_direction                           |
//
// One transaction is accepted per cycle while req_stall is low; the pipeline depth is
// set by the 30 unrolled CORDIC stages plus the front and unfolding stages.
// Reset clears the stage valid bits only; datapath registers are not reset.
// A stalled result holds the output stage while empty stages behind it keep
// filling; req_stall rises only once every stage holds a transaction.
`include "cartesian_to_polar_assert.svh"

module cartesian_to_polar import c2p_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic        [COORD_BITS:0]   rsp_distance,
   output logic        [ANGLE_BITS-1:0] rsp_direction
);

   localparam int STAGES = pipe_stages(COORD_BITS);
   localparam int BACK   = STAGES - 1;

   logic [STAGES-1:0] stage_en;
   logic [STAGES-1:0] stage_valid;

   logic signed [COORD_BITS:0]   dx;
   logic signed [COORD_BITS:0]   dy;
   logic        [COORD_BITS-1:0] abs_x_in;
   logic        [COORD_BITS-1:0] abs_y_in;
   logic        [COORD_BITS-1:0] abs_x_ff;
   logic        [COORD_BITS-1:0] abs_y_ff;
   quad_type                     quad_in;
   quad_type                     quad_ff;

   // The differences are exact at one extra bit, and their magnitudes fit
   // back into COORD_BITS.
   always_comb begin
      dx = {req_end_x[COORD_BITS-1], req_end_x} - {req_start_x[COORD_BITS-1], req_start_x};
      dy = {req_end_y[COORD_BITS-1], req_end_y} - {req_start_y[COORD_BITS-1], req_start_y};
      abs_x_in = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      abs_y_in = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      quad_in.dx_neg  = dx[COORD_BITS];
      quad_in.dy_neg  = dy[COORD_BITS];
      quad_in.is_zero = (abs_x_in == '0) && (abs_y_in == '0);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         abs_x_ff <= abs_x_in;
         abs_y_ff <= abs_y_in;
         quad_ff  <= quad_in;
      end
   end

   c2p_pipe_ctrl #(
      .STAGES (STAGES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .rsp_stall   (rsp_stall),
      .req_stall   (req_stall),
      .stage_en    (stage_en),
      .stage_valid (stage_valid)
   );

   c2p_cordic #(
      .COORD_BITS  (COORD_BITS),
      .ANGLE_BITS  (ANGLE_BITS),
      .BACK_STAGES (BACK)
   ) u_cordic (
      .clock     (clock),
      .stage_en  (stage_en[STAGES-1:1]),
      .abs_x     (abs_x_ff),
      .abs_y     (abs_y_ff),
      .quad      (quad_ff),
      .direction (rsp_direction)
   );

   c2p_isqrt #(
      .COORD_BITS  (COORD_BITS),
      .BACK_STAGES (BACK)
   ) u_isqrt (
      .clock    (clock),
      .stage_en (stage_en[STAGES-1:1]),
      .abs_x    (abs_x_ff),
      .abs_y    (abs_y_ff),
      .distance (rsp_distance)
   );

   assign rsp_valid = stage_valid[STAGES-1];

   `C2P_ASSERT_IMPL(a_stall_only_when_full, req_stall, &stage_valid)
   `C2P_ASSERT_NEXT(a_result_moves_up, stage_valid[STAGES-2] && !rsp_stall, rsp_valid)
   `C2P_ASSERT_NEXT(a_bubble_moves_up, rsp_valid && !rsp_stall && !stage_valid[STAGES-2], !rsp_valid)

endmodule

[dv/tb_cartesian_to_polar.sv]
// Testbench for cartesian_to_polar: drives point pairs, predicts distance and angle.
// Depends on c2p_pkg for the field widths and on the cartesian_to_polar RTL.
`timescale 1ns / 100ps

module tb_cartesian_to_polar;
   import c2p_pkg::*;

   localparam int CW = COORD_BITS_DEF;
   localparam int AW = ANGLE_BITS_DEF;
   localparam int N_ITERS = 30;
   localparam int DRAIN_CYCLES = 40;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct packed {
      logic [CW:0]   distance;
      logic [AW-1:0] direction;
   } polar_type;

   // atan(2^-i) with 2^32 units per full turn, rounded to nearest.
   localparam logic [31:0] ARCTAN_UNITS [N_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'd667544,   32'd333772,   32'd166886,   32'd83443,    32'd41722,
      32'd20861,    32'd10430,    32'd5215,     32'd2608,     32'd1304,
      32'd652,      32'd326,      32'd163,      32'd81,       32'd41,
      32'd20,       32'd10,       32'd5,        32'd3,        32'd1
   };

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   coord_type     req_start_x;
   coord_type     req_start_y;
   coord_type     req_end_x;
   coord_type     req_end_y;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [CW:0]   rsp_distance;
   logic [AW-1:0] rsp_direction;

   polar_type pending_polar [$];
   int        mismatches = 0;
   int        pairs_accepted = 0;
   int        results_checked = 0;
   int        input_held_cycles = 0;
   bit        req_gaps_on = 1'b0;
   bit        rsp_stall_on = 1'b0;
   int        rsp_hold_len = 0;

   cartesian_to_polar dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_distance  (rsp_distance),
      .rsp_direction (rsp_direction)
   );

   always #5 clock = ~clock;

   // Rounded length and binary angle of the segment from (sx, sy) to (ex, ey).
   function automatic polar_type predict_polar(input coord_type sx, input coord_type sy,
                                               input coord_type ex, input coord_type ey);
      longint          dx, dy, x, y, xs, ys;
      longint unsigned ax, ay, sum_sq, root, cand;
      logic [31:0]     z, a;
      polar_type       res;
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax == 0 && ay == 0) begin
         res.distance = '0;
         res.direction = '0;
         return res;
      end
      sum_sq = ax * ax + ay * ay;
      root = 0;
      for (int b = CW + 1; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= sum_sq) root = cand;
      end
      if (sum_sq > root * (root + 1)) root = root + 1;
      res.distance = root[CW:0];

      // Vectoring drives y to zero in the first quadrant; z collects the angle.
      x = longint'(ax << (60 - CW));
      y = longint'(ay << (60 - CW));
      z = '0;
      for (int i = 0; i < N_ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_UNITS[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_UNITS[i];
         end
      end
      if (dx >= 0) a = (dy >= 0) ? z : 32'd0 - z;
      else a = (dy >= 0) ? 32'h8000_0000 - z : 32'h8000_0000 + z;
      a = (a + (32'd1 << (31 - AW))) >> (32 - AW);
      res.direction = a[AW-1:0];
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100) $display("%0t: mismatch: %s", $time, msg);
   endtask

   // Offers one point pair and returns at the edge where it is taken, or after a random idle gap when gaps are on.
   task automatic send_points(input coord_type sx, input coord_type sy,
                              input coord_type ex, input coord_type ey);
      int gap;
      req_valid   <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      do @(posedge clock); while (req_stall);
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_polar.size() != 0) @(posedge clock);
   endtask

   // Prediction on every accepted pair, comparison on every accepted result.
   always @(posedge clock) begin : check_results
      polar_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_held_cycles++;
         if (req_valid && !req_stall) begin
            pending_polar.push_back(predict_polar(req_start_x, req_start_y,
                                                  req_end_x, req_end_y));
            pairs_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_polar.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending (distance %0d)",
                                         rsp_distance));
            end else begin
               want = pending_polar.pop_front();
               results_checked++;
               if (rsp_distance !== want.distance)
                  report_mismatch($sformatf("distance expected %0d, got %0d",
                                            want.distance, rsp_distance));
               if (rsp_direction !== want.direction)
                  report_mismatch($sformatf("direction expected %0d, got %0d",
                                            want.direction, rsp_direction));
            end
         end
      end
   end

   // Result side: random stall stretches, or one long hold-off when requested.
   initial begin : drive_rsp_stall
      int n;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else if (rsp_stall_on && $urandom_range(0, 99) < 30) begin
            rsp_stall <= 1'b1;
            repeat (pick_gap() + 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   task automatic test_directed_cases();
      req_gaps_on = 1'b0;
      rsp_stall_on = 1'b0;
      send_points(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_points(16'sd1234, -16'sd4321, 16'sd1234, -16'sd4321);
      send_points(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      // Largest reach in every diagonal direction.
      send_points(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
      send_points(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
      send_points(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
      send_points(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
      // Along the axes and the unit diagonals.
      send_points(16'sd0, 16'sd0, 16'sd1, 16'sd0);
      send_points(16'sd0, 16'sd0, 16'sd0, 16'sd1);
      send_points(16'sd0, 16'sd0, -16'sd1, 16'sd0);
      send_points(16'sd0, 16'sd0, 16'sd0, -16'sd1);
      send_points(16'sd0, 16'sd0, 16'sd1, 16'sd1);
      send_points(16'sd0, 16'sd0, -16'sd1, 16'sd1);
      send_points(16'sd0, 16'sd0, -16'sd1, -16'sd1);
      send_points(16'sd0, 16'sd0, 16'sd1, -16'sd1);
      send_points(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
      send_points(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
      // Just below a full turn, where the rounded angle wraps to zero.
      send_points(-16'sd32768, 16'sd0, 16'sd32767, -16'sd1);
      send_points(16'sd0, 16'sd1, 16'sd32767, 16'sd0);
      // Just either side of a half turn.
      send_points(16'sd32767, 16'sd0, -16'sd32768, 16'sd1);
      send_points(16'sd32767, 16'sd0, -16'sd32768, -16'sd1);
      send_points(-16'sd1, -16'sd1, 16'sd0, 16'sd0);
      send_points(16'sd21845, -16'sd21846, -16'sd21846, 16'sd21845);
      wait_results_drained();
   endtask

   task automatic test_uniform_points(input int count);
      coord_type sx, sy, ex, ey;
      int        pick;
      req_gaps_on = 1'b1;
      rsp_stall_on = 1'b1;
      for (int k = 0; k < count; k++) begin
         sx = coord_type'($urandom());
         sy = coord_type'($urandom());
         ex = coord_type'($urandom());
         ey = coord_type'($urandom());
         pick = $urandom_range(0, 15);
         if (pick == 0) ex = sx;
         else if (pick == 1) ey = sy;
         else if (pick == 2) begin
            ex = sx;
            ey = sy;
         end
         send_points(sx, sy, ex, ey);
      end
   endtask

   task automatic test_short_segments(input int count);
      coord_type sx, sy;
      int        dx, dy, ex, ey;
      req_gaps_on = 1'b1;
      rsp_stall_on = 1'b1;
      for (int k = 0; k < count; k++) begin
         sx = coord_type'($urandom());
         sy = coord_type'($urandom());
         dx = int'($urandom_range(0, 64)) - 32;
         dy = int'($urandom_range(0, 64)) - 32;
         ex = int'(sx) + dx;
         ey = int'(sy) + dy;
         if (ex > 32767 || ex < -32768) ex = int'(sx) - dx;
         if (ey > 32767 || ey < -32768) ey = int'(sy) - dy;
         send_points(sx, sy, coord_type'(ex), coord_type'(ey));
      end
   endtask

   // The result side holds off long enough for the pipeline to fill and
   // push back on the input, while pairs keep being offered every cycle.
   task automatic test_output_backpressure(input int count);
      req_gaps_on = 1'b0;
      rsp_stall_on = 1'b0;
      rsp_hold_len = 200;
      for (int k = 0; k < count; k++)
         send_points(coord_type'($urandom()), coord_type'($urandom()),
                     coord_type'($urandom()), coord_type'($urandom()));
      wait_results_drained();
   endtask

   task automatic test_full_rate_stream(input int count);
      req_gaps_on = 1'b0;
      rsp_stall_on = 1'b0;
      for (int k = 0; k < count; k++)
         send_points(coord_type'($urandom()), coord_type'($urandom()),
                     coord_type'($urandom()), coord_type'($urandom()));
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x   = '0;
      req_end_y   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_uniform_points(400);
      test_short_segments(400);
      test_output_backpressure(150);
      test_full_rate_stream(250);
      test_uniform_points(50);

      req_gaps_on = 1'b0;
      rsp_stall_on = 1'b0;
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Compared %0d results against %0d accepted point pairs.",
               results_checked, pairs_accepted);
      $display("Input was held off for %0d offered cycles; %0d field mismatches.",
               input_held_cycles, mismatches);
      if (mismatches == 0 && pending_polar.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("Timeout with %0d results still pending.", pending_polar.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/c2p_pkg.sv
hw/rtl/c2p_pipe_ctrl.sv
hw/rtl/c2p_cordic.sv
hw/rtl/c2p_isqrt.sv
hw/rtl/cartesian_to_polar.sv
dv/tb_cartesian_to_polar.sv
